### sv/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
package mbps_pkg;

   // Width of one scanned byte and of one pattern lane.
   localparam int LANE_BITS = 8;
   // Number of pattern and mask lanes held by the configuration registers.
   localparam int CFG_LANES = 16;
   // Width of a configuration write word.
   localparam int CSR_DATA_BITS = 64;
   // Width of the configuration register index.
   localparam int CSR_INDEX_BITS = 3;
   // Width of the pattern length register.
   localparam int LEN_BITS = 5;
   // Width of the reported match offset.
   localparam int MATCH_OFFSET_BITS = 32;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PATTERN_LOW  = 3'd0,
      REG_PATTERN_HIGH = 3'd1,
      REG_MASK_LOW     = 3'd2,
      REG_MASK_HIGH    = 3'd3,
      REG_LENGTH       = 3'd4
   } reg_index_type;

   // Pattern and mask lanes as seen by every cell of the window.
   typedef struct packed {
      logic [CFG_LANES-1:0][LANE_BITS-1:0] pattern;
      logic [CFG_LANES-1:0][LANE_BITS-1:0] mask;
      logic [LEN_BITS-1:0]                 length;
   } pattern_cfg_type;

endpackage

### sv/mbps_cell.sv
// One window cell: holds one byte of the window and checks the byte entering it against its pattern lane.
module mbps_cell #(
   parameter int INDEX = 0
) (
   input  logic                           clock,
   input  logic                           advance,
   input  logic [mbps_pkg::LANE_BITS-1:0] byte_in,
   input  mbps_pkg::pattern_cfg_type      cfg,
   output logic [mbps_pkg::LANE_BITS-1:0] byte_out,
   output logic                           hit
);
   import mbps_pkg::*;

   logic [LANE_BITS-1:0] held_byte_ff;
   logic [LANE_BITS-1:0] held_byte_in;
   logic [3:0]           lane;
   logic                 in_use;
   logic [LANE_BITS-1:0] pat;
   logic [LANE_BITS-1:0] msk;

   // The byte shifts one cell further on every accepted word.
   assign held_byte_in = advance ? byte_in : held_byte_ff;

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
   end

   assign byte_out = held_byte_ff;

   // This cell checks the byte INDEX places back, which lines up with
   // pattern lane length-1-INDEX.
   assign in_use = LEN_BITS'(INDEX) < cfg.length;
   assign lane   = 4'(cfg.length - LEN_BITS'(INDEX) - LEN_BITS'(1));
   assign pat    = cfg.pattern[lane];
   assign msk    = cfg.mask[lane];

   // The check is made on the byte that enters this cell with the current word.
   assign hit = !in_use || (msk == '0) || ((byte_in & msk) == pat);

endmodule

### sv/masked_byte_pattern_scanner.sv
// Top level of the masked byte pattern scanner: configuration, window cell chain and result register.
//
// The scanner takes one byte per clock cycle while its result register is free or being read, and
// hands out at most one result word per byte, in the cycle after the byte is accepted. The window
// is a chain of MAX_PATTERN cells; every cell compares its byte against its pattern lane in
// parallel, so a byte's full verdict is formed in the cycle it is accepted. A result word is
// produced for every byte that ends a match of the masked pattern (offset of the match's first
// byte, tuser set) and for every last byte of a region (tlast set, offset zero unless that byte
// also ends a match). A single output register sits on the result side; a new byte is taken while
// the held result is being read. The byte offset counter saturates at its maximum value.
// Configuration may only be written while no byte is in flight.
module masked_byte_pattern_scanner #(
   parameter int MAX_PATTERN = 16,
   parameter int OFFSET_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration write channel.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mbps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]    csr_data,
   // Input bytes.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [7:0] data_byte
   input  logic                                  req_tlast,   // region_last
   // Results.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mbps_pkg::MATCH_OFFSET_BITS-1:0] rsp_tdata,  // [31:0] match_offset
   output logic                                  rsp_tuser,   // [0] match_found
   output logic                                  rsp_tlast    // region_end
);
   import mbps_pkg::*;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   // Configuration registers.
   logic [CSR_DATA_BITS-1:0] pattern_low_ff,  pattern_low_in;
   logic [CSR_DATA_BITS-1:0] pattern_high_ff, pattern_high_in;
   logic [CSR_DATA_BITS-1:0] mask_low_ff,     mask_low_in;
   logic [CSR_DATA_BITS-1:0] mask_high_ff,    mask_high_in;
   logic [LEN_BITS-1:0]      length_ff,       length_in;

   // Scan state and result register.
   logic [OFFSET_BITS-1:0]       bytes_seen_ff, bytes_seen_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [MATCH_OFFSET_BITS-1:0] rsp_offset_ff, rsp_offset_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         csr_write;
   logic                         advance;
   pattern_cfg_type              cfg;
   logic [LEN_BITS-1:0]          len_eff;
   logic [LEN_BITS-1:0]          len_m1;
   logic [LANE_BITS-1:0]         chain [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]       hits;
   logic                         found;
   logic                         emit;
   logic [OFFSET_BITS-1:0]       start;
   logic [63:0]                  start_wide;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      pattern_low_in  = pattern_low_ff;
      pattern_high_in = pattern_high_ff;
      mask_low_in     = mask_low_ff;
      mask_high_in    = mask_high_ff;
      length_in       = length_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PATTERN_LOW:  pattern_low_in  = csr_data;
            REG_PATTERN_HIGH: pattern_high_in = csr_data;
            REG_MASK_LOW:     mask_low_in     = csr_data;
            REG_MASK_HIGH:    mask_high_in    = csr_data;
            REG_LENGTH:       length_in       = csr_data[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         mask_low_ff     <= '1;
         mask_high_ff    <= '1;
         length_ff       <= '0;
      end else begin
         pattern_low_ff  <= pattern_low_in;
         pattern_high_ff <= pattern_high_in;
         mask_low_ff     <= mask_low_in;
         mask_high_ff    <= mask_high_in;
         length_ff       <= length_in;
      end
   end

   // Lengths beyond the window size use the whole window.
   assign len_eff = (length_ff > LEN_BITS'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN) : length_ff;
   assign len_m1  = LEN_BITS'(len_eff - LEN_BITS'(1));

   assign cfg.pattern = {pattern_high_ff, pattern_low_ff};
   assign cfg.mask    = {mask_high_ff, mask_low_ff};
   assign cfg.length  = len_eff;

   // A byte is taken whenever the result register is free or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign advance    = req_tvalid && req_tready;

   // Window cell chain, newest byte in cell zero.
   assign chain[0] = req_tdata;

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      if (j < MAX_PATTERN - 1) begin : g_link
         mbps_cell #(
            .INDEX(j)
         ) u_cell (
            .clock   (clock),
            .advance (advance),
            .byte_in (chain[j]),
            .cfg     (cfg),
            .byte_out(chain[j+1]),
            .hit     (hits[j])
         );
      end else begin : g_tail
         mbps_cell #(
            .INDEX(j)
         ) u_cell (
            .clock   (clock),
            .advance (advance),
            .byte_in (chain[j]),
            .cfg     (cfg),
            .byte_out(),
            .hit     (hits[j])
         );
      end
   end

   // A match needs a nonzero length, enough bytes of this region, and every cell agreeing.
   assign found = (len_eff != '0) && (bytes_seen_ff >= OFFSET_BITS'(len_m1)) && (&hits);
   assign emit  = found || req_tlast;

   assign start      = bytes_seen_ff - OFFSET_BITS'(len_m1);
   assign start_wide = 64'(start);

   // Offset counter: cleared at a region end, otherwise counts up and holds at its maximum.
   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      if (advance) begin
         if (req_tlast) begin
            bytes_seen_in = '0;
         end else if (bytes_seen_ff != OFFSET_MAX) begin
            bytes_seen_in = bytes_seen_ff + OFFSET_BITS'(1);
         end
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_last_in   = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_found_in  = found;
            rsp_offset_in = found ? start_wide[MATCH_OFFSET_BITS-1:0] : '0;
            rsp_last_in   = req_tlast;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_offset_ff <= rsp_offset_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_offset_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### dv/tb_masked_byte_pattern_scanner.sv
// Self-checking testbench for the masked byte pattern scanner with a scoreboard of match reports.
module tb_masked_byte_pattern_scanner;
   import mbps_pkg::*;

   localparam int MAX_PATTERN = 16;
   localparam int OFFSET_BITS = 32;
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_STALL_CYCLES = 150;
   localparam int CYCLE_LIMIT = 200000;

   // One report word as the scanner hands it out.
   typedef struct packed {
      logic                         found;
      logic [MATCH_OFFSET_BITS-1:0] offset;
      logic                         region_end;
   } scan_report_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [CSR_DATA_BITS-1:0]     csr_data = '0;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [7:0]                   req_tdata = '0;   // [7:0] data_byte
   logic                         req_tlast = 1'b0; // region_last
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [MATCH_OFFSET_BITS-1:0] rsp_tdata;        // [31:0] match_offset
   logic                         rsp_tuser;        // [0] match_found
   logic                         rsp_tlast;        // region_end

   // Our own copy of the scanner's configuration and window state.
   logic [CFG_LANES-1:0][LANE_BITS-1:0] cfg_pattern = '0;
   logic [CFG_LANES-1:0][LANE_BITS-1:0] cfg_mask = '1;
   logic [LEN_BITS-1:0]                 cfg_len = '0;
   logic [LANE_BITS-1:0]                window [MAX_PATTERN] = '{default: '0};
   logic [OFFSET_BITS-1:0]              bytes_seen = '0;
   scan_report_type                     pending_reports [$];
   scan_report_type                     oldest;

   int mismatch_count = 0;
   int send_idle_pct = 30;
   int recv_idle_pct = 52;
   int stalls_requested = 0;
   int stalls_served = 0;
   int stall_left = 0;
   int watchdog_cycles = 0;

   masked_byte_pattern_scanner #(
      .MAX_PATTERN(MAX_PATTERN),
      .OFFSET_BITS(OFFSET_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Prints one line per mismatch and counts every one.
   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // Shifts one accepted byte into the window and queues the report it causes, if any.
   task automatic scan_byte(input logic [7:0] data, input logic last);
      int unsigned            span;
      logic                   hit;
      logic [OFFSET_BITS-1:0] start;
      span = (cfg_len > MAX_PATTERN) ? MAX_PATTERN : cfg_len;
      for (int i = MAX_PATTERN - 1; i > 0; i--)
         window[i] = window[i - 1];
      window[0] = data;
      hit = 1'b0;
      start = '0;
      // A match needs span bytes of this region, the current byte included.
      if (span > 0 && bytes_seen >= span - 1) begin
         hit = 1'b1;
         for (int k = 0; k < span; k++)
            if (cfg_mask[k] != '0 && (window[span - 1 - k] & cfg_mask[k]) != cfg_pattern[k])
               hit = 1'b0;
         if (hit)
            start = bytes_seen - (span - 1);
      end
      // The last byte restarts the region; otherwise the offset counts up and saturates.
      if (last) begin
         bytes_seen = '0;
         window = '{default: '0};
      end else if (bytes_seen != '1) begin
         bytes_seen++;
      end
      if (hit || last)
         pending_reports.push_back('{found: hit, offset: start[MATCH_OFFSET_BITS-1:0],
                                     region_end: last});
   endtask

   // Offers one byte after a random gap and waits until the scanner takes the word.
   task automatic send_byte(input logic [7:0] data, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      scan_byte(data, last);
   endtask

   // Stops offering bytes and waits until every queued report has come back.
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register and keeps csr_valid high for a following write.
   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_PATTERN_LOW:  cfg_pattern[7:0] = value;
         REG_PATTERN_HIGH: cfg_pattern[15:8] = value;
         REG_MASK_LOW:     cfg_mask[7:0] = value;
         REG_MASK_HIGH:    cfg_mask[15:8] = value;
         REG_LENGTH:       cfg_len = value[LEN_BITS-1:0];
         default: ;
      endcase
   endtask

   // Writes all five registers once the scanner has gone idle.
   task automatic load_config(input logic [CFG_LANES-1:0][LANE_BITS-1:0] pat,
                              input logic [CFG_LANES-1:0][LANE_BITS-1:0] msk,
                              input logic [LEN_BITS-1:0] len);
      wait_until_idle();
      write_reg(REG_PATTERN_LOW, pat[7:0]);
      write_reg(REG_PATTERN_HIGH, pat[15:8]);
      write_reg(REG_MASK_LOW, msk[7:0]);
      write_reg(REG_MASK_HIGH, msk[15:8]);
      write_reg(REG_LENGTH, CSR_DATA_BITS'(len));
      csr_valid <= 1'b0;
   endtask

   // Sends about count bytes: mostly pattern instances with random free bits, some noise,
   // and some instances cut short by an early region end.
   task automatic send_stream(input int count);
      logic [7:0] burst [$];
      int         span;
      int         cut;
      int         lane;
      logic       closes;
      span = (cfg_len == 0) ? 4 : ((cfg_len > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_len));
      while (count > 0) begin
         burst.delete();
         if ($urandom_range(99) < 65) begin
            for (int k = 0; k < span; k++)
               burst.push_back((cfg_pattern[k] & cfg_mask[k]) | (8'($urandom) & ~cfg_mask[k]));
         end else begin
            // Noise partly drawn from pattern bytes, so that partial matches occur.
            repeat ($urandom_range(1, 6)) begin
               lane = $urandom_range(MAX_PATTERN - 1);
               burst.push_back(($urandom_range(1) != 0) ? cfg_pattern[lane] : 8'($urandom));
            end
         end
         closes = ($urandom_range(99) < 20);
         if ($urandom_range(99) < 15 && burst.size() > 1) begin
            cut = $urandom_range(1, burst.size() - 1);
            while (burst.size() > cut)
               void'(burst.pop_back());
            closes = 1'b1;
         end
         for (int i = 0; i < burst.size(); i++)
            send_byte(burst[i], closes && i == burst.size() - 1);
         count -= burst.size();
      end
   endtask

   // After reset the length is zero: only region ends report.
   task automatic test_region_defaults();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b1);
   endtask

   // Overlapping matches, then a region shorter than the pattern.
   task automatic test_overlapping_matches();
      logic [CFG_LANES-1:0][LANE_BITS-1:0] pat;
      logic [CFG_LANES-1:0][LANE_BITS-1:0] msk;
      pat = '0;
      pat[0] = 8'hA5;
      pat[1] = 8'hA5;
      msk = '1;
      load_config(pat, msk, LEN_BITS'(2));
      send_byte(8'hA5, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'hA5, 1'b1);
      send_byte(8'hA5, 1'b1);
   endtask

   // Partial masks and a wildcard lane, then pattern bits outside the mask.
   task automatic test_masks_and_wildcards();
      logic [CFG_LANES-1:0][LANE_BITS-1:0] pat;
      logic [CFG_LANES-1:0][LANE_BITS-1:0] msk;
      pat = '0;
      msk = '1;
      pat[0] = 8'h10;
      msk[0] = 8'hF0;
      pat[1] = 8'h99;
      msk[1] = 8'h00;
      pat[2] = 8'h0F;
      msk[2] = 8'h0F;
      load_config(pat, msk, LEN_BITS'(3));
      send_byte(8'h1C, 1'b0);
      send_byte(8'h77, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h2C, 1'b0);
      send_byte(8'h77, 1'b0);
      send_byte(8'h0F, 1'b1);
      pat[0] = 8'h0F;
      msk[0] = 8'hF0;
      load_config(pat, msk, LEN_BITS'(1));
      send_byte(8'h0F, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // Random configurations, each followed by a stream shaped to hit it.
   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      logic [CFG_LANES-1:0][LANE_BITS-1:0] pat;
      logic [CFG_LANES-1:0][LANE_BITS-1:0] msk;
      logic [LEN_BITS-1:0]                 len;
      int                                  pick;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (5) begin
         case ($urandom_range(5))
            0: len = '0;
            1: len = LEN_BITS'(1);
            2: len = LEN_BITS'(MAX_PATTERN);
            3: len = LEN_BITS'($urandom_range(MAX_PATTERN + 1, 31));
            default: len = LEN_BITS'($urandom_range(2, MAX_PATTERN - 1));
         endcase
         for (int k = 0; k < CFG_LANES; k++) begin
            pick = $urandom_range(99);
            msk[k] = (pick < 25) ? 8'h00 : ((pick < 65) ? 8'hFF : 8'($urandom));
            pat[k] = ($urandom_range(9) == 0) ? 8'($urandom) : (8'($urandom) & msk[k]);
         end
         // Now and then whole registers at their extremes.
         case ($urandom_range(7))
            0: begin
               pat = '1;
               msk = '1;
            end
            1: msk = '0;
            2: pat = '0;
            default: ;
         endcase
         load_config(pat, msk, len);
         send_stream(80);
      end
   endtask

   // Every byte matches while the receiver holds off, so the scanner must stall its input.
   task automatic test_input_stall_under_backpressure();
      logic [CFG_LANES-1:0][LANE_BITS-1:0] pat;
      logic [CFG_LANES-1:0][LANE_BITS-1:0] msk;
      pat = '0;
      msk = '0;
      load_config(pat, msk, LEN_BITS'(1));
      send_idle_pct = 0;
      stalls_requested++;
      send_stream(60);
   endtask

   // Receiver side: random ready, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stalls_served != stalls_requested) begin
         stalls_served <= stalls_served + 1;
         stall_left <= LONG_STALL_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compares each accepted report word with the oldest pending one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("report word with nothing pending", '0, rsp_tdata);
         end else begin
            oldest = pending_reports.pop_front();
            if (rsp_tuser !== oldest.found)
               report_mismatch("match_found", 32'(oldest.found), 32'(rsp_tuser));
            if (rsp_tdata !== oldest.offset)
               report_mismatch("match_offset", oldest.offset, rsp_tdata);
            if (rsp_tlast !== oldest.region_end)
               report_mismatch("region_end", 32'(oldest.region_end), 32'(rsp_tlast));
         end
      end
   end

   // Ends a run that hangs.
   initial begin
      while (watchdog_cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         watchdog_cycles++;
      end
      $display("FAIL masked_byte_pattern_scanner");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_region_defaults();
      test_overlapping_matches();
      test_masks_and_wildcards();
      test_random_traffic(30, 52);
      test_random_traffic(52, 30);
      test_random_traffic(0, 0);
      test_input_stall_under_backpressure();
      wait_until_idle();
      if (mismatch_count == 0)
         $display("PASS masked_byte_pattern_scanner");
      else
         $display("FAIL masked_byte_pattern_scanner");
      $finish;
   end

endmodule
